[design/dedup_fifo_job_queue_macros.svh]
// assertion shorthands used by the checker file
`ifndef DEDUP_FIFO_JOB_QUEUE_MACROS_SVH
`define DEDUP_FIFO_JOB_QUEUE_MACROS_SVH

// plain clocked property, off during reset
`define DFJQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// same-cycle implication
`define DFJQ_ASSERT_IMP(lbl, ante, cons, msg) \
    `DFJQ_ASSERT(lbl, (ante) |-> (cons), msg)

// next-cycle implication
`define DFJQ_ASSERT_NXT(lbl, ante, cons, msg) \
    `DFJQ_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

[design/dfjq_pkg.sv]
package dfjq_pkg;

    localparam int DFJQ_DEPTH = 10;

    localparam int REQ_W     = 3;
    localparam int KEY_W     = 32;
    localparam int PATH_W    = 32;
    localparam int BYTES_W   = 40;
    localparam int ERR_W     = 8;
    localparam int IDX_IN_W  = 4;
    localparam int CODE_W    = 2;
    localparam int CNT_OUT_W = 4;

    typedef enum logic [REQ_W-1:0] {
        REQ_ENQ    = 3'd0,
        REQ_MARK   = 3'd1,
        REQ_PROG   = 3'd2,
        REQ_FINISH = 3'd3,
        REQ_CANCEL = 3'd4,
        REQ_READ   = 3'd5,
        REQ_LAST   = 3'd6
    } req_t;

    typedef enum logic [CODE_W-1:0] {
        RC_OK      = 2'd0,
        RC_DUP     = 2'd1,
        RC_FULL    = 2'd2,
        RC_IGNORED = 2'd3
    } res_code_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_HMOD,
        ST_RDATA,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [PATH_W-1:0]  path;
        logic [BYTES_W-1:0] total;
        logic [BYTES_W-1:0] done;
        logic               busy;
    } entry_t;

    typedef struct packed {
        res_code_t            code;
        logic [CNT_OUT_W-1:0] queue_count;
        logic                 entry_valid;
        logic [KEY_W-1:0]     entry_key;
        logic [PATH_W-1:0]    entry_path;
        logic [BYTES_W-1:0]   entry_total;
        logic [BYTES_W-1:0]   entry_done;
        logic                 entry_downloading;
        logic                 last_ok;
        logic [ERR_W-1:0]     last_error;
    } result_t;

endpackage

[design/dfjq_ram.sv]
module dfjq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[design/dedup_fifo_job_queue.sv]
// channel  | handshake          | fields
// ---------+--------------------+------------------------------------------------
// request  | in_valid/in_ready  | req_type item_key path_handle total_bytes
//          |                    | done_bytes finish_ok error_code read_index
// result   | out_valid/out_ready| result_code queue_count entry_* last_ok last_error
//
// one request at a time; entries live in a single-port-read ring ram
// enqueue: search scans the queued keys, one key read a cycle, to a match or the end
// mark, progress, finish: hmod; read entry: rdata; empty queue or index past count skip
// cancel, read last, unused code: to done; next word taken the cycle after the result
// a result waiting on out_ready does not block the next request, only its result
// rst_n clears count, head, last result and handshake state; ram is not cleared
module dedup_fifo_job_queue #(
    parameter int QUEUE_DEPTH = dfjq_pkg::DFJQ_DEPTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [dfjq_pkg::REQ_W-1:0]     req_type,
    input  logic [dfjq_pkg::KEY_W-1:0]     item_key,
    input  logic [dfjq_pkg::PATH_W-1:0]    path_handle,
    input  logic [dfjq_pkg::BYTES_W-1:0]   total_bytes,
    input  logic [dfjq_pkg::BYTES_W-1:0]   done_bytes,
    input  logic                           finish_ok,
    input  logic [dfjq_pkg::ERR_W-1:0]     error_code,
    input  logic [dfjq_pkg::IDX_IN_W-1:0]  read_index,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [dfjq_pkg::CODE_W-1:0]    result_code,
    output logic [dfjq_pkg::CNT_OUT_W-1:0] queue_count,
    output logic                           entry_valid,
    output logic [dfjq_pkg::KEY_W-1:0]     entry_key,
    output logic [dfjq_pkg::PATH_W-1:0]    entry_path,
    output logic [dfjq_pkg::BYTES_W-1:0]   entry_total,
    output logic [dfjq_pkg::BYTES_W-1:0]   entry_done,
    output logic                           entry_downloading,
    output logic                           last_ok,
    output logic [dfjq_pkg::ERR_W-1:0]     last_error
);

    import dfjq_pkg::*;

    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam int CMP_W = (CNT_W > IDX_IN_W) ? CNT_W : IDX_IN_W;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [IDX_W-1:0]    head_reg, head_next;
    logic [CNT_W-1:0]    scan_reg, scan_next;
    logic                pend_reg, pend_next;
    logic                out_valid_reg, out_valid_next;
    result_t             res_reg, res_next;
    result_t             out_reg, out_next;

    req_t                req_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [PATH_W-1:0]   path_reg;
    logic [BYTES_W-1:0]  total_reg;
    logic [BYTES_W-1:0]  prog_done_reg;
    logic                ok_reg;
    logic [ERR_W-1:0]    err_reg;

    logic                prev_valid_reg;
    logic [KEY_W-1:0]    prev_key_reg;
    logic [PATH_W-1:0]   prev_path_reg;
    logic                prev_ok_reg;
    logic [ERR_W-1:0]    prev_err_reg;
    logic                prev_load;

    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    entry_t              ram_wdata;
    logic [IDX_W-1:0]    ram_raddr;
    entry_t              rd_entry;

    logic                in_fire;
    logic                scan_issue;
    logic [CNT_W-1:0]    rd_off;

    // slot of queue position off, counted from the head
    function automatic logic [IDX_W-1:0] ring_addr(input logic [IDX_W-1:0] head,
                                                   input logic [CNT_W-1:0] off);
        logic [SUM_W-1:0] s;
        s = SUM_W'(head) + SUM_W'(off);
        if (s >= SUM_W'(QUEUE_DEPTH))
        begin
            s = s - SUM_W'(QUEUE_DEPTH);
        end
        return s[IDX_W-1:0];
    endfunction

    dfjq_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_dfjq_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (rd_entry)
    );

    assign in_fire = in_valid & in_ready;
    assign rd_off  = CNT_W'(read_index);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        head_next      = head_reg;
        scan_next      = scan_reg;
        pend_next      = 1'b0;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg & ~out_ready;
        in_ready       = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = head_reg;
        ram_wdata      = rd_entry;
        ram_raddr      = head_reg;
        prev_load      = 1'b0;
        scan_issue     = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    res_next      = '0;
                    res_next.code = RC_OK;
                    state_next    = ST_DONE;
                    unique case (req_t'(req_type))
                        REQ_ENQ:
                        begin
                            scan_next  = '0;
                            state_next = ST_SEARCH;
                        end
                        REQ_MARK, REQ_PROG, REQ_FINISH:
                        begin
                            if (count_reg == '0)
                            begin
                                res_next.code = RC_IGNORED;
                            end
                            else
                            begin
                                ram_raddr  = head_reg;
                                state_next = ST_HMOD;
                            end
                        end
                        REQ_CANCEL:
                        begin
                            count_next = '0;
                        end
                        REQ_READ:
                        begin
                            if (CMP_W'(read_index) < CMP_W'(count_reg))
                            begin
                                ram_raddr  = ring_addr(head_reg, rd_off);
                                state_next = ST_RDATA;
                            end
                        end
                        REQ_LAST:
                        begin
                            res_next.entry_valid = prev_valid_reg;
                            res_next.entry_key   = prev_key_reg;
                            res_next.entry_path  = prev_path_reg;
                            res_next.last_ok     = prev_ok_reg;
                            res_next.last_error  = prev_err_reg;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_SEARCH:
            begin
                // one key read issued per cycle, compared when it returns
                scan_issue = scan_reg < count_reg;
                if (scan_issue)
                begin
                    ram_raddr = ring_addr(head_reg, scan_reg);
                    scan_next = scan_reg + CNT_W'(1);
                end
                pend_next = scan_issue;
                if (pend_reg && (rd_entry.key == key_reg))
                begin
                    res_next.code = RC_DUP;
                    state_next    = ST_DONE;
                end
                else if (!scan_issue && !pend_reg)
                begin
                    if (count_reg == CNT_W'(QUEUE_DEPTH))
                    begin
                        res_next.code = RC_FULL;
                    end
                    else
                    begin
                        ram_we     = 1'b1;
                        ram_waddr  = ring_addr(head_reg, count_reg);
                        ram_wdata  = '{key: key_reg, path: path_reg, total: total_reg,
                                       done: '0, busy: 1'b0};
                        count_next = count_reg + CNT_W'(1);
                    end
                    state_next = ST_DONE;
                end
            end

            ST_HMOD:
            begin
                // head entry is on the read port; mark and progress write back in place
                if (rd_entry.key == key_reg)
                begin
                    unique case (req_reg)
                        REQ_MARK:
                        begin
                            ram_we         = 1'b1;
                            ram_wdata.busy = 1'b1;
                        end
                        REQ_PROG:
                        begin
                            ram_we          = 1'b1;
                            ram_wdata.done  = prog_done_reg;
                            ram_wdata.total = total_reg;
                        end
                        REQ_FINISH:
                        begin
                            prev_load  = 1'b1;
                            head_next  = (head_reg == IDX_W'(QUEUE_DEPTH - 1)) ? '0
                                       : head_reg + IDX_W'(1);
                            count_next = count_reg - CNT_W'(1);
                        end
                        default:
                        begin
                        end
                    endcase
                end
                else
                begin
                    res_next.code = RC_IGNORED;
                end
                state_next = ST_DONE;
            end

            ST_RDATA:
            begin
                res_next.entry_valid       = 1'b1;
                res_next.entry_key         = rd_entry.key;
                res_next.entry_path        = rd_entry.path;
                res_next.entry_total       = rd_entry.total;
                res_next.entry_done        = rd_entry.done;
                res_next.entry_downloading = rd_entry.busy;
                state_next                 = ST_DONE;
            end

            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_next             = res_reg;
                    out_next.queue_count = CNT_OUT_W'(count_reg);
                    out_valid_next       = 1'b1;
                    state_next           = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            head_reg       <= '0;
            scan_reg       <= '0;
            pend_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            prev_valid_reg <= 1'b0;
            prev_key_reg   <= '0;
            prev_path_reg  <= '0;
            prev_ok_reg    <= 1'b0;
            prev_err_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            head_reg      <= head_next;
            scan_reg      <= scan_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            if (prev_load)
            begin
                prev_valid_reg <= 1'b1;
                prev_key_reg   <= key_reg;
                prev_path_reg  <= rd_entry.path;
                prev_ok_reg    <= ok_reg;
                prev_err_reg   <= err_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        out_reg <= out_next;
        if (in_fire)
        begin
            req_reg       <= req_t'(req_type);
            key_reg       <= item_key;
            path_reg      <= path_handle;
            total_reg     <= total_bytes;
            prog_done_reg <= done_bytes;
            ok_reg        <= finish_ok;
            err_reg       <= error_code;
        end
    end

    assign out_valid         = out_valid_reg;
    assign result_code       = out_reg.code;
    assign queue_count       = out_reg.queue_count;
    assign entry_valid       = out_reg.entry_valid;
    assign entry_key         = out_reg.entry_key;
    assign entry_path        = out_reg.entry_path;
    assign entry_total       = out_reg.entry_total;
    assign entry_done        = out_reg.entry_done;
    assign entry_downloading = out_reg.entry_downloading;
    assign last_ok           = out_reg.last_ok;
    assign last_error        = out_reg.last_error;

endmodule

[design/dfjq_checker.sv]
`include "dedup_fifo_job_queue_macros.svh"

module dfjq_checker #(
    parameter int QUEUE_DEPTH = dfjq_pkg::DFJQ_DEPTH
) (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_ready,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic [dfjq_pkg::CODE_W-1:0]    result_code,
    input logic [dfjq_pkg::CNT_OUT_W-1:0] queue_count,
    input logic                           entry_valid,
    input logic [dfjq_pkg::KEY_W-1:0]     entry_key
);

    import dfjq_pkg::*;

    // words accepted whose result has not yet been taken
    logic [1:0] pend_cnt_reg, pend_cnt_next;

    always_comb
    begin
        pend_cnt_next = pend_cnt_reg + 2'(in_valid & in_ready) - 2'(out_valid & out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_cnt_reg <= '0;
        end
        else
        begin
            pend_cnt_reg <= pend_cnt_next;
        end
    end

    `DFJQ_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(result_code) && $stable(entry_key), "result changed while stalled")
    `DFJQ_ASSERT_IMP(a_no_orphan, out_valid, pend_cnt_reg != 2'd0, "result with no request behind it")
    `DFJQ_ASSERT(a_pend_bound, pend_cnt_reg != 2'd3, "more than two requests in flight")
    `DFJQ_ASSERT_IMP(a_code_fields, out_valid && (result_code != RC_OK), !entry_valid, "entry valid on a rejected request")
    `DFJQ_ASSERT_IMP(a_full_count, out_valid && (result_code == RC_FULL), (QUEUE_DEPTH > 15) || (queue_count == CNT_OUT_W'(QUEUE_DEPTH)), "full reported below depth")

endmodule

bind dedup_fifo_job_queue dfjq_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dfjq_checker (.*);
